### rtl/four_motor_tick_pwm_controller_macros.svh
// Assertion macros used by the top-level RTL file of the four-motor PWM controller.
`ifndef FOUR_MOTOR_TICK_PWM_CONTROLLER_MACROS_SVH
`define FOUR_MOTOR_TICK_PWM_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high.
`define FMTPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds during reset.
`define FMTPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define FMTPC_ASSERT(label, prop, msg)
`define FMTPC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/fmtpc_pkg.sv
// Types, constants and codes of the four-motor PWM controller.
package fmtpc_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_DRIVE  = 2'd1,
      FUNC_MOTION = 2'd2,
      FUNC_SPEED  = 2'd3
   } fmtpc_func_type;

   typedef enum logic {
      CSR_PWM_PERIOD      = 1'b0,
      CSR_REVERSAL_ENABLE = 1'b1
   } fmtpc_csr_type;

   localparam logic [7:0] PAT_FRONT = 8'hAA;
   localparam logic [7:0] PAT_BACK  = 8'h55;
   localparam logic [7:0] PAT_STOP  = 8'h00;

   localparam logic [3:0][7:0] BRAKE_MASK = {8'h03, 8'h0C, 8'h30, 8'hC0};

   localparam logic [7:0] PWM_PERIOD_RESET = 8'd100;

   localparam logic signed [11:0] DRIVE_MIN = 12'sd0;
   localparam logic signed [11:0] DRIVE_MAX = 12'sd100;
   localparam logic signed [9:0]  WEIGHTED_MIN = 10'sd35;
   localparam logic signed [9:0]  WEIGHTED_MAX = 10'sd80;
   localparam logic signed [9:0]  PLAIN_MIN = 10'sd20;
   localparam logic signed [9:0]  PLAIN_MAX = 10'sd100;

   typedef struct packed {
      fmtpc_func_type     func;
      logic signed [9:0]  speed;
      logic signed [9:0]  balance;
      logic [7:0]         pattern;
      logic               weighted;
   } fmtpc_item_type;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic       reversal_enable;
   } fmtpc_cfg_type;

   typedef struct packed {
      logic [7:0]      tick_count;
      logic [3:0][7:0] duty;
      logic [3:0]      armed;
      logic [7:0]      port_value;
      logic [7:0]      motion_pattern;
   } fmtpc_state_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } fmtpc_result_type;

endpackage

### rtl/fmtpc_cmd.sv
// Command logic: next channel state and the port words caused by one command.
module fmtpc_cmd (
   input  fmtpc_pkg::fmtpc_item_type   item,
   input  fmtpc_pkg::fmtpc_cfg_type    cfg,
   input  fmtpc_pkg::fmtpc_state_type  state,
   output fmtpc_pkg::fmtpc_state_type  state_next,
   output fmtpc_pkg::fmtpc_result_type result
);
   import fmtpc_pkg::*;

   logic [8:0]        tick_next;
   logic              period_hit;
   logic signed [11:0] bal_ext;
   logic signed [11:0] left_raw;
   logic signed [11:0] right_raw;
   logic [7:0]        left_duty;
   logic [7:0]        right_duty;
   logic signed [9:0] set_lo;
   logic signed [9:0] set_hi;
   logic [7:0]        set_duty;

   assign tick_next  = {1'b0, state.tick_count} + 9'd1;
   assign period_hit = tick_next >= {1'b0, cfg.pwm_period};

   // Reversal mode doubles the balance before mixing.
   assign bal_ext   = cfg.reversal_enable ? {{1{item.balance[9]}}, item.balance, 1'b0}
                                          : {{2{item.balance[9]}}, item.balance};
   assign left_raw  = {{2{item.speed[9]}}, item.speed} + bal_ext;
   assign right_raw = {{2{item.speed[9]}}, item.speed} - bal_ext;

   always_comb begin
      if (left_raw < DRIVE_MIN) begin
         left_duty = 8'd0;
      end else if (left_raw > DRIVE_MAX) begin
         left_duty = DRIVE_MAX[7:0];
      end else begin
         left_duty = left_raw[7:0];
      end
      if (right_raw < DRIVE_MIN) begin
         right_duty = 8'd0;
      end else if (right_raw > DRIVE_MAX) begin
         right_duty = DRIVE_MAX[7:0];
      end else begin
         right_duty = right_raw[7:0];
      end
   end

   assign set_lo = item.weighted ? WEIGHTED_MIN : PLAIN_MIN;
   assign set_hi = item.weighted ? WEIGHTED_MAX : PLAIN_MAX;

   always_comb begin
      if (item.speed < set_lo) begin
         set_duty = set_lo[7:0];
      end else if (item.speed > set_hi) begin
         set_duty = set_hi[7:0];
      end else begin
         set_duty = item.speed[7:0];
      end
   end

   always_comb begin
      logic [7:0] pv;
      logic [2:0] n;
      state_next   = state;
      result.count = 3'd0;
      result.bytes = '0;
      pv = state.port_value;
      n  = 3'd0;
      unique case (item.func)
         FUNC_TICK: begin
            if (period_hit) begin
               state_next.tick_count = 8'd0;
               state_next.armed      = 4'b1111;
               state_next.port_value = state.motion_pattern;
               result.count          = 3'd1;
               result.bytes[0]       = state.motion_pattern;
            end else begin
               state_next.tick_count = tick_next[7:0];
               // Channels fire in port order; each word carries the bits set so far.
               for (int i = 0; i < 4; i++) begin
                  if (state.armed[i] && (tick_next >= {1'b0, state.duty[i]})) begin
                     pv = pv | BRAKE_MASK[i];
                     state_next.armed[i] = 1'b0;
                     result.bytes[n[1:0]] = pv;
                     n = n + 3'd1;
                  end
               end
               state_next.port_value = pv;
               result.count          = n;
            end
         end
         FUNC_DRIVE: begin
            if (cfg.reversal_enable) begin
               if (left_raw < DRIVE_MIN || right_raw < DRIVE_MIN) begin
                  state_next.motion_pattern = PAT_BACK;
               end
            end else begin
               state_next.motion_pattern = PAT_FRONT;
            end
            state_next.duty = {right_duty, right_duty, left_duty, left_duty};
         end
         FUNC_MOTION: begin
            state_next.motion_pattern = item.pattern;
            state_next.duty = {4{item.speed[7:0]}};
         end
         FUNC_SPEED: begin
            if (item.speed != 10'sd0) begin
               state_next.duty = {4{set_duty}};
            end else begin
               state_next.motion_pattern = PAT_STOP;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

### rtl/four_motor_tick_pwm_controller.sv
// Top level of the four-motor tick PWM controller.
//
//  channel | direction | tdata / data               | tuser / side
//  req_    | in        | speed, balance, pattern    | func, weighted
//  rsp_    | out       | port_byte                  | tlast = last word of a tick
//  csr_    | in        | write data (8 bits)        | index 0 period, 1 reversal
//
// A command is taken into an input register, then processed when the buffer can load;
// this loads a four-word result buffer and updates the channel state.
// A command that emits no word is processed every cycle while the buffer is empty;
// behind a tick that emits words, the next command waits until its last word is taken.
// Reset initialises the control and channel state at once; no clearing pass is needed.
// A stalled result port holds the buffer and backs up into req_tready.
module four_motor_tick_pwm_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // speed[9:0], balance[19:10], pattern[27:20], zero
   input  logic [2:0]  req_tuser,   // func[1:0], weighted[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // port_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);
   import fmtpc_pkg::*;
   `include "four_motor_tick_pwm_controller_macros.svh"

   logic              in_valid_ff;
   fmtpc_item_type    in_item_ff;
   fmtpc_item_type    in_item_in;
   fmtpc_cfg_type     cfg_ff;
   fmtpc_state_type   state_ff;
   fmtpc_state_type   state_in;
   fmtpc_result_type  cmd_result;
   logic [3:0][7:0]   obuf_ff;
   logic [2:0]        obuf_rem_ff;
   logic [1:0]        obuf_idx_ff;
   logic              buf_can_load;
   logic              proc_fire;
   logic              rsp_take;

   assign in_item_in.func     = fmtpc_func_type'(req_tuser[1:0]);
   assign in_item_in.weighted = req_tuser[2];
   assign in_item_in.speed    = req_tdata[9:0];
   assign in_item_in.balance  = req_tdata[19:10];
   assign in_item_in.pattern  = req_tdata[27:20];

   assign rsp_take     = rsp_tvalid && rsp_tready;
   assign buf_can_load = (obuf_rem_ff == 3'd0) || ((obuf_rem_ff == 3'd1) && rsp_tready);
   assign proc_fire    = in_valid_ff && buf_can_load;
   assign req_tready   = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period      <= PWM_PERIOD_RESET;
         cfg_ff.reversal_enable <= 1'b0;
      end else if (csr_we) begin
         unique case (fmtpc_csr_type'(csr_addr))
            CSR_PWM_PERIOD:      cfg_ff.pwm_period      <= csr_wdata;
            CSR_REVERSAL_ENABLE: cfg_ff.reversal_enable <= csr_wdata[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   fmtpc_cmd u_cmd (
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (cmd_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.tick_count     <= 8'd0;
         state_ff.duty           <= '0;
         state_ff.armed          <= 4'b1111;
         state_ff.port_value     <= PAT_STOP;
         state_ff.motion_pattern <= PAT_FRONT;
      end else if (proc_fire) begin
         state_ff <= state_in;
      end
   end

   // A fresh load wins over the take of the final pending word.
   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_rem_ff <= 3'd0;
         obuf_idx_ff <= 2'd0;
      end else if (proc_fire) begin
         obuf_rem_ff <= cmd_result.count;
         obuf_idx_ff <= 2'd0;
      end else if (rsp_take) begin
         obuf_rem_ff <= obuf_rem_ff - 3'd1;
         obuf_idx_ff <= obuf_idx_ff + 2'd1;
      end
      if (proc_fire) begin
         obuf_ff <= cmd_result.bytes;
      end
   end

   assign rsp_tvalid = obuf_rem_ff != 3'd0;
   assign rsp_tdata  = obuf_ff[obuf_idx_ff];
   assign rsp_tlast  = obuf_rem_ff == 3'd1;

   `FMTPC_ASSERT(a_hold_input, (in_valid_ff && !buf_can_load) |-> !req_tready, "input taken while result buffer busy")
   `FMTPC_ASSERT(a_more_words, (rsp_take && !rsp_tlast) |=> rsp_tvalid, "words of a tick lost before the last one")
   `FMTPC_ASSERT(a_load_shows, (proc_fire && cmd_result.count != 3'd0) |=> (rsp_tvalid && obuf_idx_ff == 2'd0), "loaded result not presented from its first word")
   `FMTPC_ASSERT(a_rem_bound, obuf_rem_ff <= 3'd4, "result buffer count beyond four words")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the four-motor tick PWM controller.
module tb_top;
   import fmtpc_pkg::*;

   typedef struct packed {
      logic [7:0] port_byte;
      logic       last;
   } port_word_type;

   // One step of the directed part: a register write or a command.
   // Where typed is set, the listed words replace the predicted ones.
   typedef struct packed {
      logic            csr;
      fmtpc_csr_type   reg_idx;
      logic [7:0]      reg_val;
      fmtpc_item_type  cmd;
      logic            typed;
      logic [2:0]      typed_n;
      logic [3:0][7:0] typed_bytes;   // first word in the low byte
   } plan_row_type;

   localparam int PLAN_ROWS = 32;
   localparam int PHASE_ITEMS = 55;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // speed[9:0], balance[19:10], pattern[27:20], zero
   logic [2:0]  req_tuser;   // func[1:0], weighted[2]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // port_byte[7:0]
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_addr;
   logic [7:0]  csr_wdata;

   // Predicted controller state and register copies.
   logic [7:0]      cfg_period;
   logic            cfg_reversal;
   logic [7:0]      ctl_count;
   logic [3:0][7:0] ctl_duty;
   logic [3:0]      ctl_armed;
   logic [7:0]      ctl_port;
   logic [7:0]      ctl_pattern;

   port_word_type pending_port_words[$];
   port_word_type want_word;
   port_word_type got_word;

   plan_row_type directed_plan [PLAN_ROWS];
   logic [7:0] phase_period [8] = '{8'd6, 8'd1, 8'd255, 8'd0, 8'd12, 8'd3, 8'd25, 8'd9};
   logic [7:0] phase_reversal = 8'b1001_0110;

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int commands_sent;
   int words_checked;

   four_motor_tick_pwm_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("four_motor_tick_pwm_controller: mismatch");
      $finish;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Applies one command to the predicted state and returns the port words it emits.
   function automatic int predict_port_words(input fmtpc_item_type c,
                                             output logic [3:0][7:0] words);
      logic [8:0] next_count;
      int sp;
      int bal;
      int left;
      int right;
      int n;
      words = '0;
      n = 0;
      sp = $signed(c.speed);
      bal = $signed(c.balance);
      case (c.func)
         FUNC_TICK: begin
            // The advanced count is compared at nine bits, so it never wraps.
            next_count = {1'b0, ctl_count} + 9'd1;
            if (next_count >= {1'b0, cfg_period}) begin
               ctl_count = '0;
               ctl_armed = '1;
               ctl_port = ctl_pattern;
               words[0] = ctl_port;
               n = 1;
            end else begin
               ctl_count = next_count[7:0];
               for (int i = 0; i < 4; i++) begin
                  if (ctl_armed[i] && next_count >= {1'b0, ctl_duty[i]}) begin
                     ctl_port = ctl_port | BRAKE_MASK[i];
                     ctl_armed[i] = 1'b0;
                     words[n] = ctl_port;
                     n++;
                  end
               end
            end
         end
         FUNC_DRIVE: begin
            if (cfg_reversal) begin
               left = sp + 2 * bal;
               right = sp - 2 * bal;
               if (left < 0 || right < 0) ctl_pattern = PAT_BACK;
            end else begin
               left = sp + bal;
               right = sp - bal;
               ctl_pattern = PAT_FRONT;
            end
            left = clamp_int(left, DRIVE_MIN, DRIVE_MAX);
            right = clamp_int(right, DRIVE_MIN, DRIVE_MAX);
            ctl_duty[0] = 8'(left);
            ctl_duty[1] = 8'(left);
            ctl_duty[2] = 8'(right);
            ctl_duty[3] = 8'(right);
         end
         FUNC_MOTION: begin
            ctl_pattern = c.pattern;
            for (int i = 0; i < 4; i++) ctl_duty[i] = c.speed[7:0];
         end
         FUNC_SPEED: begin
            if (sp != 0) begin
               if (c.weighted) left = clamp_int(sp, WEIGHTED_MIN, WEIGHTED_MAX);
               else left = clamp_int(sp, PLAIN_MIN, PLAIN_MAX);
               for (int i = 0; i < 4; i++) ctl_duty[i] = 8'(left);
            end else begin
               ctl_pattern = PAT_STOP;
            end
         end
      endcase
      return n;
   endfunction

   task automatic note_mismatch(input string what, input port_word_type want,
                                input port_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected byte %h last %b, got byte %h last %b",
                  what, want.port_byte, want.last, got.port_byte, got.last);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_command(input fmtpc_item_type c, input logic typed,
                               input logic [2:0] typed_n, input logic [3:0][7:0] typed_bytes);
      logic [3:0][7:0] words;
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'b0, c.pattern, c.balance, c.speed};
      req_tuser = {c.weighted, c.func};
      do @(posedge clock); while (!req_tready);
      n = predict_port_words(c, words);
      if (typed) begin
         n = typed_n;
         words = typed_bytes;
      end
      for (int i = 0; i < n; i++) pending_port_words.push_back('{words[i], i == n - 1});
      commands_sent++;
      @(negedge clock);
   endtask

   // Registers change only once every expected word has drained and the
   // block has had time to finish a tick that emits nothing.
   task automatic write_register(input fmtpc_csr_type idx, input logic [7:0] val);
      req_tvalid = 1'b0;
      while (pending_port_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      if (idx == CSR_PWM_PERIOD) cfg_period = val;
      else cfg_reversal = val[0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = '{rsp_tdata, rsp_tlast};
         words_checked++;
         if (pending_port_words.size() == 0) begin
            note_mismatch("port word with nothing expected", '0, got_word);
         end else begin
            want_word = pending_port_words.pop_front();
            if (got_word !== want_word) note_mismatch("port word", want_word, got_word);
         end
      end
   end

   initial begin
      fmtpc_item_type cmd;
      int pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_addr = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      mismatches = 0;
      commands_sent = 0;
      words_checked = 0;
      cfg_period = PWM_PERIOD_RESET;
      cfg_reversal = 1'b0;
      ctl_count = '0;
      ctl_duty = '0;
      ctl_armed = '1;
      ctl_port = PAT_STOP;
      ctl_pattern = PAT_FRONT;

      directed_plan = '{
         // After reset every duty is zero, so the first tick brakes all four channels.
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd4, {8'hFF, 8'hFC, 8'hF0, 8'hC0}},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b1, CSR_PWM_PERIOD, 8'd3, '0, 1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd1, 32'h0000_00AA},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_DRIVE, 10'sd2, 10'sd1, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_DRIVE, 10'sd511, 10'sh200, 8'h00, 1'b1},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_DRIVE, 10'sh200, 10'sd511, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b1, CSR_REVERSAL_ENABLE, 8'd1, '0, 1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_DRIVE, 10'sd10, -10'sd20, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_DRIVE, 10'sd100, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         // A negative speed wraps to its low byte as the duty.
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_MOTION, -10'sd1, 10'sd0, 8'h81, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_SPEED, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_SPEED, 10'sh200, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_SPEED, 10'sd511, 10'sd0, 8'h00, 1'b1},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_SPEED, 10'sd1, 10'sd0, 8'h00, 1'b1},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_SPEED, 10'sd3, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd0, '0},
         // With a zero period every tick rewrites the pattern, here the stop pattern.
         '{1'b1, CSR_PWM_PERIOD, 8'd0, '0, 1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd1, 32'h0000_0000},
         '{1'b1, CSR_PWM_PERIOD, 8'd1, '0, 1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_MOTION, 10'sd0, 10'sd0, 8'hFF, 1'b0},
           1'b1, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b1, 3'd1, 32'h0000_00FF},
         '{1'b1, CSR_PWM_PERIOD, 8'd255, '0, 1'b0, 3'd0, '0},
         '{1'b1, CSR_REVERSAL_ENABLE, 8'd0, '0, 1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0},
         '{1'b0, CSR_PWM_PERIOD, 8'd0, '{FUNC_TICK, 10'sd0, 10'sd0, 8'h00, 1'b0},
           1'b0, 3'd0, '0}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (directed_plan[r].csr)
            write_register(directed_plan[r].reg_idx, directed_plan[r].reg_val);
         else
            send_command(directed_plan[r].cmd, directed_plan[r].typed,
                         directed_plan[r].typed_n, directed_plan[r].typed_bytes);
      end

      for (int phase = 0; phase < 8; phase++) begin
         write_register(CSR_PWM_PERIOD, phase_period[phase]);
         write_register(CSR_REVERSAL_ENABLE, {7'b0, phase_reversal[phase]});
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 35;
               rsp_stall_pct = 35;
            end
         endcase
         // Mostly ticks with small duties, so channels fire and periods wrap often.
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            cmd.speed = 10'($urandom);
            cmd.balance = 10'($urandom);
            cmd.pattern = 8'($urandom);
            cmd.weighted = 1'($urandom);
            if (pick < 62) begin
               cmd.func = FUNC_TICK;
            end else if (pick < 76) begin
               cmd.func = FUNC_DRIVE;
               if ($urandom_range(3) != 0) begin
                  cmd.speed = 10'($urandom_range(40)) - 10'sd8;
                  cmd.balance = 10'($urandom_range(24)) - 10'sd12;
               end
            end else if (pick < 88) begin
               cmd.func = FUNC_MOTION;
               if ($urandom_range(3) != 0) cmd.speed = 10'($urandom_range(30));
            end else begin
               cmd.func = FUNC_SPEED;
               if ($urandom_range(4) == 0) cmd.speed = '0;
               else if ($urandom_range(1) != 0) cmd.speed = 10'($urandom_range(120));
            end
            send_command(cmd, 1'b0, 3'd0, '0);
         end
      end

      req_tvalid = 1'b0;
      while (pending_port_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d commands and checked %0d port words.", commands_sent, words_checked);
      $display("Periods from 0 to 255, reversal on and off, under four idle and stall mixes.");
      if (mismatches == 0) begin
         $display("four_motor_tick_pwm_controller: match");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("four_motor_tick_pwm_controller: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/fmtpc_pkg.sv
rtl/fmtpc_cmd.sv
rtl/four_motor_tick_pwm_controller.sv
tb/tb_top.sv
